@@ rtl/core/positional_list_engine_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared property forms used by the checker; clocked, with reset disabling.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ple: same-cycle property violated");

// Next-cycle implication.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ple: next-cycle property violated");

`endif

@@ rtl/core/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Transfer types and operation and status codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam logic [2:0] KIND_INS_HEAD = 3'd0;
   localparam logic [2:0] KIND_INS_TAIL = 3'd1;
   localparam logic [2:0] KIND_INS_POS  = 3'd2;
   localparam logic [2:0] KIND_DEL_HEAD = 3'd3;
   localparam logic [2:0] KIND_DEL_TAIL = 3'd4;
   localparam logic [2:0] KIND_DEL_POS  = 3'd5;
   localparam logic [2:0] KIND_LIST     = 3'd6;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_BADPOS = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_res;
      logic [5:0]         index;
      logic [5:0]         length;
      logic               last;
   } rsp_type;

endpackage

@@ rtl/core/positional_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed 32-bit values held packed in one synchronous RAM.
// Inserts shift the entries from the slot to the tail up by one, then write the
// value; deletes shift the entries behind the removed slot down by one. Each then
// reports its status. Shifts move one entry per cycle. A list request presents its
// values in order, one value per cycle while the output is not stalled.
// One request is in progress at a time; the next is taken once it is done.
// Synchronous reset empties the list; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_data
);

   // Address width for the RAM and count width able to hold CAPACITY itself.
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   // Comparison width: wide enough for the count, position and one extra.
   localparam int XW = (CW > 6) ? CW + 1 : 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_SHIFT,
      ST_LIST_OUT,
      ST_REPORT
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    dst_ff, dst_in;
   logic [AW-1:0]    end_ff, end_in;
   logic [31:0]      value_ff, value_in;
   logic [1:0]       status_ff, status_in;
   ple_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // The element RAM: one write port, one registered read port.
   logic [31:0]      mem [CAPACITY];
   logic [31:0]      rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic [XW-1:0]    rd_x;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;

   logic [XW-1:0]    cnt_x;
   logic [XW-1:0]    pos_x;
   logic [XW-1:0]    dst_x;
   logic [XW-1:0]    at_x;
   logic             out_free;
   logic             list_last;

   assign cnt_x     = XW'(count_ff);
   assign pos_x     = XW'(req_data.position);
   assign dst_x     = XW'(dst_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_last = (dst_x + XW'(1)) == cnt_x;

   // Read addresses that fall past the end only occur on the final step of a
   // walk, where the data is never used; they are folded to entry zero.
   assign rd_addr   = (rd_x < XW'(CAPACITY)) ? AW'(rd_x) : '0;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dst_in       = dst_ff;
      end_in       = end_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = dst_ff;
      wr_data      = rd_data_ff;
      rd_x         = '0;
      at_x         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_data.value;
               case (req_data.kind)
                  ple_pkg::KIND_INS_HEAD, ple_pkg::KIND_INS_TAIL,
                  ple_pkg::KIND_INS_POS: begin
                     if (req_data.kind == ple_pkg::KIND_INS_HEAD) begin
                        at_x = '0;
                     end else if (req_data.kind == ple_pkg::KIND_INS_TAIL) begin
                        at_x = cnt_x;
                     end else begin
                        at_x = pos_x - XW'(1);
                     end
                     // The position check takes precedence over the full check.
                     if (req_data.kind == ple_pkg::KIND_INS_POS &&
                         (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
                        status_in = ple_pkg::STATUS_BADPOS;
                        state_in  = ST_REPORT;
                     end else if (cnt_x == XW'(CAPACITY)) begin
                        status_in = ple_pkg::STATUS_FULL;
                        state_in  = ST_REPORT;
                     end else begin
                        status_in = ple_pkg::STATUS_OK;
                        end_in    = AW'(at_x);
                        if (at_x == cnt_x) begin
                           dst_in   = AW'(at_x);
                           state_in = ST_INS_PUT;
                        end else begin
                           // Shift from the tail downwards; fetch the last entry now.
                           dst_in   = AW'(cnt_x);
                           rd_x     = cnt_x - XW'(1);
                           state_in = ST_INS_SHIFT;
                        end
                     end
                  end
                  ple_pkg::KIND_DEL_HEAD, ple_pkg::KIND_DEL_TAIL,
                  ple_pkg::KIND_DEL_POS: begin
                     if (req_data.kind == ple_pkg::KIND_DEL_HEAD) begin
                        at_x = '0;
                     end else if (req_data.kind == ple_pkg::KIND_DEL_TAIL) begin
                        at_x = cnt_x - XW'(1);
                     end else begin
                        at_x = pos_x - XW'(1);
                     end
                     // The empty check takes precedence over the position check.
                     if (cnt_x == '0) begin
                        status_in = ple_pkg::STATUS_EMPTY;
                        state_in  = ST_REPORT;
                     end else if (req_data.kind == ple_pkg::KIND_DEL_POS &&
                                  (pos_x == '0 || pos_x > cnt_x)) begin
                        status_in = ple_pkg::STATUS_BADPOS;
                        state_in  = ST_REPORT;
                     end else begin
                        status_in = ple_pkg::STATUS_OK;
                        if (at_x == cnt_x - XW'(1)) begin
                           count_in = count_ff - CW'(1);
                           state_in = ST_REPORT;
                        end else begin
                           // Shift upwards from the removed slot; fetch its successor.
                           dst_in   = AW'(at_x);
                           rd_x     = at_x + XW'(1);
                           state_in = ST_DEL_SHIFT;
                        end
                     end
                  end
                  ple_pkg::KIND_LIST: begin
                     if (cnt_x == '0) begin
                        status_in = ple_pkg::STATUS_EMPTY;
                        state_in  = ST_REPORT;
                     end else begin
                        dst_in   = '0;
                        rd_x     = '0;
                        state_in = ST_LIST_OUT;
                     end
                  end
                  default: begin
                     // The unused code is taken and dropped without a result.
                  end
               endcase
            end
         end

         ST_INS_SHIFT: begin
            // Entry dst-1 was read last cycle; it moves up into dst.
            wr_en = 1'b1;
            if (dst_x == XW'(end_ff) + XW'(1)) begin
               dst_in   = end_ff;
               state_in = ST_INS_PUT;
            end else begin
               dst_in = dst_ff - AW'(1);
               rd_x   = dst_x - XW'(2);
            end
         end

         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            state_in = ST_REPORT;
         end

         ST_DEL_SHIFT: begin
            // Entry dst+1 was read last cycle; it moves down into dst.
            wr_en = 1'b1;
            if (dst_x + XW'(2) == cnt_x) begin
               count_in = count_ff - CW'(1);
               state_in = ST_REPORT;
            end else begin
               dst_in = dst_ff + AW'(1);
               rd_x   = dst_x + XW'(2);
            end
         end

         ST_LIST_OUT: begin
            // Keep the read address on the current entry until it is taken.
            rd_x = dst_x;
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = ple_pkg::STATUS_OK;
               rsp_in.value_res = rd_data_ff;
               rsp_in.index     = 6'(dst_x + XW'(1));
               rsp_in.length    = 6'(count_ff);
               rsp_in.last      = list_last;
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  dst_in = dst_ff + AW'(1);
                  rd_x   = dst_x + XW'(1);
               end
            end
         end

         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.value_res = '0;
               rsp_in.index     = '0;
               rsp_in.length    = 6'(count_ff);
               rsp_in.last      = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dst_ff    <= dst_in;
      end_ff    <= end_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ rtl/core/ple_checker.sv @@
// ----------------------------------------------------------------------------
// ple_checker
// Port-level properties of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_assert.svh"

module ple_checker #(
   parameter int CAPACITY = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ple_pkg::rsp_type rsp_data
);

   // A waiting result is held until it is transferred.
   `PLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Any result other than ok is a single closing status with no payload.
   `PLE_ASSERT_NOW(a_status_only, clock, reset, rsp_valid && rsp_data.status != ple_pkg::STATUS_OK, rsp_data.last && rsp_data.index == '0 && rsp_data.value_res == '0)

   // Only a listing produces results that are not the last; they carry an index.
   `PLE_ASSERT_NOW(a_list_stream, clock, reset, rsp_valid && !rsp_data.last, rsp_data.status == ple_pkg::STATUS_OK && rsp_data.index != '0)

   // A full status reports the list at capacity.
   `PLE_ASSERT_NOW(a_full_length, clock, reset, rsp_valid && rsp_data.status == ple_pkg::STATUS_FULL, rsp_data.length == 6'(CAPACITY))

endmodule

bind positional_list_engine_top ple_checker #(
   .CAPACITY (CAPACITY)
) u_ple_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
